### src/least_loaded_unit_allocator_macros.svh
// Assertion macros used by the allocator's scan module.
`ifndef LEAST_LOADED_UNIT_ALLOCATOR_MACROS_SVH
`define LEAST_LOADED_UNIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLUA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/llua_pkg.sv
// Shared types and constants of the least-loaded unit allocator.
package llua_pkg;

	localparam int COST_W    = 4;
	localparam int UNIT_W    = 3;
	localparam int TOTAL_W   = 17;
	localparam int CFG_IDX_W = 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic DIR_DOWN = 1'b0;
	localparam logic DIR_UP   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_COST_DOWNLINK = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COST_UPLINK   = 4'd1;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} store_ctrl_t;

endpackage

### src/llua_if.sv
// Handshake channel interfaces of the least-loaded unit allocator.
interface llua_req_if;
	logic valid;
	logic ready;
	logic operation;
	logic direction;

	modport source (output valid, output operation, output direction, input ready);
	modport sink (input valid, input operation, input direction, output ready);
endinterface

interface llua_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [llua_pkg::UNIT_W-1:0]  chosen_unit;
	logic [llua_pkg::TOTAL_W-1:0] max_total_load;

	modport source (output valid, output chosen_unit, output max_total_load, input ready);
	modport sink (input valid, input chosen_unit, input max_total_load, output ready);
endinterface

interface llua_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [llua_pkg::CFG_IDX_W-1:0] index;
	logic [llua_pkg::COST_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/llua_store.sv
// Load counter store: one entry per unit, valid bits cleared all at once.
module llua_store #(
	parameter int NUM_UNITS = 8,
	parameter int LOAD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  llua_pkg::store_ctrl_t        ctrl,
	input  logic [$clog2(NUM_UNITS)-1:0] addr,
	input  logic [2*LOAD_BITS-1:0]       wr_data,
	output logic [2*LOAD_BITS-1:0]       rd_data
);

	localparam int ENT_W = 2 * LOAD_BITS;

	logic [ENT_W-1:0]     mem [NUM_UNITS];
	logic [NUM_UNITS-1:0] valid_q;
	logic [ENT_W-1:0]     rd_data_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= '0;
			end else if (ctrl.wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

### src/llua_scan.sv
// Sequencer and shared compare unit that scans the store one unit per cycle.
`include "least_loaded_unit_allocator_macros.svh"

module llua_scan #(
	parameter int NUM_UNITS = 8,
	parameter int LOAD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           operation,
	input  logic                           direction,
	input  logic [llua_pkg::COST_W-1:0]    cost_downlink,
	input  logic [llua_pkg::COST_W-1:0]    cost_uplink,
	input  logic                           out_free,
	input  logic [2*LOAD_BITS-1:0]         rd_data,
	output logic                           in_ready,
	output llua_pkg::store_ctrl_t          ctrl,
	output logic [$clog2(NUM_UNITS)-1:0]   addr,
	output logic [2*LOAD_BITS-1:0]         wr_data,
	output logic                           done,
	output logic [llua_pkg::UNIT_W-1:0]    chosen_unit,
	output logic [llua_pkg::TOTAL_W-1:0]   max_total_load
);

	localparam int IDX_W = $clog2(NUM_UNITS);
	localparam int ENT_W = 2 * LOAD_BITS;
	localparam int TOT_W = LOAD_BITS + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_UNITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            cmp_idx_q;
	logic                        rd_pend_q;
	logic                        dir_q;
	logic [ENT_W-1:0]            best_q;
	logic [IDX_W-1:0]            pick_q;
	logic [TOT_W-1:0]            max_q;
	logic [llua_pkg::UNIT_W-1:0] res_unit_q;
	logic [llua_pkg::TOTAL_W-1:0] res_max_q;

	logic [LOAD_BITS-1:0] rd_dn;
	logic [LOAD_BITS-1:0] rd_up;
	logic [LOAD_BITS-1:0] cand;
	logic [LOAD_BITS-1:0] cur;
	logic                 first;
	logic                 take;
	logic [TOT_W-1:0]     tot;
	logic                 take_max;
	logic [LOAD_BITS-1:0] sel_load;
	logic [LOAD_BITS-1:0] other_load;
	logic [TOT_W-1:0]     sum;
	logic [LOAD_BITS-1:0] sat_load;
	logic [TOT_W-1:0]     new_tot;
	logic [TOT_W-1:0]     fin_max;
	logic [ENT_W-1:0]     new_entry;

	always_comb begin
		rd_dn    = rd_data[LOAD_BITS-1:0];
		rd_up    = rd_data[ENT_W-1:LOAD_BITS];
		cand     = (dir_q == llua_pkg::DIR_UP) ? rd_up : rd_dn;
		cur      = (dir_q == llua_pkg::DIR_UP) ? best_q[ENT_W-1:LOAD_BITS]
		                                       : best_q[LOAD_BITS-1:0];
		first    = (cmp_idx_q == '0);
		take     = first || ((dir_q == llua_pkg::DIR_UP) ? (cand <= cur) : (cand < cur));
		tot      = {1'b0, rd_dn} + {1'b0, rd_up};
		take_max = first || (tot > max_q);

		sel_load   = (dir_q == llua_pkg::DIR_UP) ? best_q[ENT_W-1:LOAD_BITS]
		                                         : best_q[LOAD_BITS-1:0];
		other_load = (dir_q == llua_pkg::DIR_UP) ? best_q[LOAD_BITS-1:0]
		                                         : best_q[ENT_W-1:LOAD_BITS];
		sum = {1'b0, sel_load} + ((dir_q == llua_pkg::DIR_UP)
			? TOT_W'(cost_uplink) : TOT_W'(cost_downlink));
		sat_load  = sum[LOAD_BITS] ? '1 : sum[LOAD_BITS-1:0];
		new_tot   = {1'b0, other_load} + {1'b0, sat_load};
		fin_max   = (new_tot > max_q) ? new_tot : max_q;
		new_entry = (dir_q == llua_pkg::DIR_UP) ? {sat_load, other_load}
		                                        : {other_load, sat_load};
	end

	always_comb begin
		ctrl.rd_en = (state_q == ST_SCAN);
		ctrl.wr_en = (state_q == ST_WRITE);
		ctrl.clear = start && (operation == llua_pkg::OP_CLEAR);
	end

	assign addr           = (state_q == ST_WRITE) ? pick_q : idx_q;
	assign wr_data        = new_entry;
	assign in_ready       = (state_q == ST_IDLE);
	assign done           = (state_q == ST_DONE);
	assign chosen_unit    = res_unit_q;
	assign max_total_load = res_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cmp_idx_q  <= '0;
			rd_pend_q  <= 1'b0;
			dir_q      <= llua_pkg::DIR_DOWN;
			best_q     <= '0;
			pick_q     <= '0;
			max_q      <= '0;
			res_unit_q <= '0;
			res_max_q  <= '0;
		end else begin
			rd_pend_q <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				cmp_idx_q <= idx_q;
			end
			if (rd_pend_q) begin
				if (take) begin
					best_q <= rd_data;
					pick_q <= cmp_idx_q;
				end
				if (take_max) begin
					max_q <= tot;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (operation == llua_pkg::OP_CLEAR) begin
							res_unit_q <= '0;
							res_max_q  <= '0;
							state_q    <= ST_DONE;
						end else begin
							dir_q   <= direction;
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					res_unit_q <= llua_pkg::UNIT_W'(pick_q);
					res_max_q  <= llua_pkg::TOTAL_W'(fin_max);
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LLUA_ASSERT_NOW(a_ctrl_exclusive, clk, arst_n, 1'b1, $onehot0({ctrl.rd_en, ctrl.wr_en, ctrl.clear}), "store control overlaps")
	`LLUA_ASSERT_NEXT(a_alloc_starts_scan, clk, arst_n, start && (operation == llua_pkg::OP_ALLOC), (state_q == ST_SCAN) && (idx_q == '0), "allocation did not start its scan")
	`LLUA_ASSERT_NOW(a_pick_in_range, clk, arst_n, state_q == ST_WRITE, pick_q <= LAST_IDX, "picked unit out of range")
	`LLUA_ASSERT_NEXT(a_write_to_done, clk, arst_n, state_q == ST_WRITE, state_q == ST_DONE, "write step not followed by result")

endmodule

### src/least_loaded_unit_allocator.sv
// Least-loaded unit allocator: an allocate transaction scans every unit's load
// counter one unit per cycle through the single read port of the load store,
// then drains the last read, writes the chosen unit's updated load back, hands
// off the result and returns to idle before the next transaction can be
// accepted. A clear transaction goes from idle straight to the hand-off. The
// result waits in an output register, and the next request is taken once the
// previous result has been handed to that register.
module least_loaded_unit_allocator #(
	parameter int NUM_UNITS = 8,
	parameter int LOAD_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	llua_req_if.sink   req,
	llua_rsp_if.source rsp,
	llua_cfg_if.sink   cfg
);

	localparam int IDX_W = $clog2(NUM_UNITS);
	localparam int ENT_W = 2 * LOAD_BITS;

	logic [llua_pkg::COST_W-1:0]  cost_downlink_q;
	logic [llua_pkg::COST_W-1:0]  cost_uplink_q;
	logic                         rsp_valid_q;
	logic [llua_pkg::UNIT_W-1:0]  rsp_unit_q;
	logic [llua_pkg::TOTAL_W-1:0] rsp_max_q;

	logic                         start;
	logic                         out_free;
	logic                         scan_ready;
	logic                         scan_done;
	llua_pkg::store_ctrl_t        store_ctrl;
	logic [IDX_W-1:0]             store_addr;
	logic [ENT_W-1:0]             store_wr_data;
	logic [ENT_W-1:0]             store_rd_data;
	logic [llua_pkg::UNIT_W-1:0]  scan_unit;
	logic [llua_pkg::TOTAL_W-1:0] scan_max;

	assign start     = req.valid && scan_ready;
	assign req.ready = scan_ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.chosen_unit    = rsp_unit_q;
	assign rsp.max_total_load = rsp_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_downlink_q <= llua_pkg::COST_W'(1);
			cost_uplink_q   <= llua_pkg::COST_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				llua_pkg::REG_COST_DOWNLINK: cost_downlink_q <= cfg.data;
				llua_pkg::REG_COST_UPLINK:   cost_uplink_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (scan_done && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done && out_free) begin
			rsp_unit_q <= scan_unit;
			rsp_max_q  <= scan_max;
		end
	end

	llua_scan #(
		.NUM_UNITS (NUM_UNITS),
		.LOAD_BITS (LOAD_BITS)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.operation      (req.operation),
		.direction      (req.direction),
		.cost_downlink  (cost_downlink_q),
		.cost_uplink    (cost_uplink_q),
		.out_free       (out_free),
		.rd_data        (store_rd_data),
		.in_ready       (scan_ready),
		.ctrl           (store_ctrl),
		.addr           (store_addr),
		.wr_data        (store_wr_data),
		.done           (scan_done),
		.chosen_unit    (scan_unit),
		.max_total_load (scan_max)
	);

	llua_store #(
		.NUM_UNITS (NUM_UNITS),
		.LOAD_BITS (LOAD_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (store_ctrl),
		.addr    (store_addr),
		.wr_data (store_wr_data),
		.rd_data (store_rd_data)
	);

endmodule

### tb/tb_least_loaded_unit_allocator.sv
// Self-checking testbench of the least-loaded unit allocator with a built-in load predictor.
module tb_least_loaded_unit_allocator;

	localparam int NUM_UNITS     = 8;
	localparam int LOAD_BITS     = 16;
	localparam int DRAIN_CYCLES  = NUM_UNITS + 8;
	localparam int WATCHDOG_MAX  = 3000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 120;
	localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

	typedef struct packed {
		logic operation;
		logic direction;
	} alloc_req_t;

	typedef struct packed {
		logic [llua_pkg::UNIT_W-1:0]  chosen_unit;
		logic [llua_pkg::TOTAL_W-1:0] max_total_load;
	} grant_t;

	logic clk;
	logic arst_n;

	llua_req_if req();
	llua_rsp_if rsp();
	llua_cfg_if cfg();

	least_loaded_unit_allocator #(
		.NUM_UNITS(NUM_UNITS),
		.LOAD_BITS(LOAD_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	alloc_req_t pending_reqs[$];
	grant_t expected_grants[$];
	alloc_req_t in_flight;

	logic [LOAD_BITS-1:0] down_load[NUM_UNITS];
	logic [LOAD_BITS-1:0] up_load[NUM_UNITS];
	logic [llua_pkg::COST_W-1:0] down_cost;
	logic [llua_pkg::COST_W-1:0] up_cost;

	int sender_idle_pct;
	int receiver_stall_pct;
	int queued_reqs;
	int checked_results;
	int mismatch_count;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic grant_t apply_request(alloc_req_t r);
		grant_t g;
		int pick;
		logic [llua_pkg::TOTAL_W-1:0] sum;
		logic [llua_pkg::TOTAL_W-1:0] best_total;
		logic [llua_pkg::TOTAL_W-1:0] unit_total;
		g = '0;
		pick = 0;
		if (r.operation == llua_pkg::OP_CLEAR) begin
			for (int u = 0; u < NUM_UNITS; u++) begin
				down_load[u] = '0;
				up_load[u] = '0;
			end
			return g;
		end
		if (r.direction == llua_pkg::DIR_DOWN) begin
			pick = 0;
			for (int u = 1; u < NUM_UNITS; u++)
				if (down_load[u] < down_load[pick])
					pick = u;
			sum = llua_pkg::TOTAL_W'(down_load[pick]) + llua_pkg::TOTAL_W'(down_cost);
			down_load[pick] = (sum > llua_pkg::TOTAL_W'(LOAD_MAX)) ? LOAD_MAX
				: sum[LOAD_BITS-1:0];
		end else begin
			pick = NUM_UNITS - 1;
			for (int u = NUM_UNITS - 2; u >= 0; u--)
				if (up_load[u] < up_load[pick])
					pick = u;
			sum = llua_pkg::TOTAL_W'(up_load[pick]) + llua_pkg::TOTAL_W'(up_cost);
			up_load[pick] = (sum > llua_pkg::TOTAL_W'(LOAD_MAX)) ? LOAD_MAX
				: sum[LOAD_BITS-1:0];
		end
		best_total = '0;
		for (int u = 0; u < NUM_UNITS; u++) begin
			unit_total = llua_pkg::TOTAL_W'(down_load[u]) + llua_pkg::TOTAL_W'(up_load[u]);
			if (unit_total > best_total)
				best_total = unit_total;
		end
		g.chosen_unit = pick[llua_pkg::UNIT_W-1:0];
		g.max_total_load = best_total;
		return g;
	endfunction

	task automatic note_mismatch(string what, int unsigned expv, int unsigned actv);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %0s: expected %0d, got %0d", what, expv, actv);
	endtask

	// Request driver: records each accepted transaction and offers the next pending item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_grants.push_back(apply_request(in_flight));
			if (!req.valid || req.ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_flight = pending_reqs.pop_front();
					req.valid <= 1'b1;
					req.operation <= in_flight.operation;
					req.direction <= in_flight.direction;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compares each delivered result with the oldest prediction.
	always @(posedge clk) begin : grant_monitor
		grant_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_grants.size() == 0) begin
					note_mismatch("unexpected result, unit", 32'(0), 32'(rsp.chosen_unit));
				end else begin
					want = expected_grants.pop_front();
					checked_results++;
					if (rsp.chosen_unit !== want.chosen_unit)
						note_mismatch("chosen_unit", 32'(want.chosen_unit),
							32'(rsp.chosen_unit));
					if (rsp.max_total_load !== want.max_total_load)
						note_mismatch("max_total_load", 32'(want.max_total_load),
							32'(rsp.max_total_load));
				end
			end
			rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("[least_loaded_unit_allocator] ERROR");
			$finish;
		end
	end

	task automatic queue_req(logic op, logic dir);
		alloc_req_t r;
		r.operation = op;
		r.direction = dir;
		pending_reqs.push_back(r);
		queued_reqs++;
	endtask

	task automatic set_mode(int mode);
		int idle_by_mode[4];
		int stall_by_mode[4];
		idle_by_mode = '{0, 81, 0, 13};
		stall_by_mode = '{0, 0, 81, 13};
		sender_idle_pct = idle_by_mode[mode % 4];
		receiver_stall_pct = stall_by_mode[mode % 4];
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (checked_results != queued_reqs);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [llua_pkg::CFG_IDX_W-1:0] idx,
		logic [llua_pkg::COST_W-1:0] value);
		@(posedge clk);
		cfg.index <= idx;
		cfg.data <= value;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == llua_pkg::REG_COST_DOWNLINK)
			down_cost = value;
		else if (idx == llua_pkg::REG_COST_UPLINK)
			up_cost = value;
	endtask

	task automatic write_unknown_reg();
		write_reg(llua_pkg::CFG_IDX_W'($urandom_range(2, (1 << llua_pkg::CFG_IDX_W) - 1)),
			llua_pkg::COST_W'($urandom_range(0, (1 << llua_pkg::COST_W) - 1)));
	endtask

	initial begin : stimulus
		int dcost;
		int ucost;
		int clear_pct;
		int up_pct;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = llua_pkg::OP_ALLOC;
		req.direction = llua_pkg::DIR_DOWN;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = llua_pkg::REG_COST_DOWNLINK;
		cfg.data = '0;
		in_flight = '0;
		for (int u = 0; u < NUM_UNITS; u++) begin
			down_load[u] = '0;
			up_load[u] = '0;
		end
		down_cost = 1;
		up_cost = 1;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		queued_reqs = 0;
		checked_results = 0;
		mismatch_count = 0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset costs: ties go low for downlink and high for uplink, then a clear.
		set_mode(0);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_CLEAR, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		wait_drained();

		// Zero downlink cost keeps picking the same unit.
		write_reg(llua_pkg::REG_COST_DOWNLINK, llua_pkg::COST_W'(0));
		write_reg(llua_pkg::REG_COST_UPLINK, llua_pkg::COST_W'(15));
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		queue_req(llua_pkg::OP_CLEAR, llua_pkg::DIR_UP);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		wait_drained();

		write_unknown_reg();
		write_reg(llua_pkg::REG_COST_DOWNLINK, llua_pkg::COST_W'(15));
		write_reg(llua_pkg::REG_COST_UPLINK, llua_pkg::COST_W'(0));
		write_unknown_reg();
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		wait_drained();

		// Several downlink rounds at high cost, then a cost change, more downlink rounds and uplink rounds.
		write_reg(llua_pkg::REG_COST_UPLINK, llua_pkg::COST_W'(15));
		queue_req(llua_pkg::OP_CLEAR, llua_pkg::DIR_DOWN);
		for (int i = 0; i < NUM_UNITS * 4; i++)
			queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		wait_drained();
		write_reg(llua_pkg::REG_COST_DOWNLINK, llua_pkg::COST_W'(14));
		for (int i = 0; i < NUM_UNITS * 3; i++)
			queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_DOWN);
		for (int i = 0; i < 2 * NUM_UNITS; i++)
			queue_req(llua_pkg::OP_ALLOC, llua_pkg::DIR_UP);
		queue_req(llua_pkg::OP_CLEAR, llua_pkg::DIR_DOWN);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 6)
				0: begin
					dcost = 0;
					ucost = 0;
				end
				1: begin
					dcost = 15;
					ucost = 15;
				end
				2: begin
					dcost = 0;
					ucost = 15;
				end
				3: begin
					dcost = 15;
					ucost = 0;
				end
				default: begin
					dcost = $urandom_range(0, 15);
					ucost = $urandom_range(0, 15);
				end
			endcase
			if ($urandom_range(3) == 0)
				write_unknown_reg();
			write_reg(llua_pkg::REG_COST_DOWNLINK, llua_pkg::COST_W'(dcost));
			write_reg(llua_pkg::REG_COST_UPLINK, llua_pkg::COST_W'(ucost));
			set_mode(p);
			clear_pct = (p % 3 == 0) ? 1 : 6;
			up_pct = (p % 4 == 1) ? 85 : ((p % 4 == 2) ? 15 : 50);
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_req(($urandom_range(99) < clear_pct) ? llua_pkg::OP_CLEAR
					: llua_pkg::OP_ALLOC,
					($urandom_range(99) < up_pct) ? llua_pkg::DIR_UP : llua_pkg::DIR_DOWN);
			wait_drained();
		end

		if (mismatch_count == 0 && expected_grants.size() == 0) begin
			$display("[least_loaded_unit_allocator] OK");
		end else begin
			$display("[least_loaded_unit_allocator] ERROR");
		end
		$finish;
	end

endmodule

### files.f
+incdir+src
src/llua_pkg.sv
src/llua_if.sv
src/llua_store.sv
src/llua_scan.sv
src/least_loaded_unit_allocator.sv
tb/tb_least_loaded_unit_allocator.sv
